>>> src/drmt_pkg.sv
package drmt_pkg;

  localparam int unsigned RANGE_SLOTS_DEFAULT = 16;
  localparam int unsigned ADDR_W = 32;

  localparam logic [ADDR_W-1:0] END_LIMIT = 32'hFFFF_FFFF;

  localparam logic REQ_MARK  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [2:0] OUT_IGNORED   = 3'd0;
  localparam logic [2:0] OUT_MERGED    = 3'd1;
  localparam logic [2:0] OUT_APPENDED  = 3'd2;
  localparam logic [2:0] OUT_OVERWROTE = 3'd3;
  localparam logic [2:0] OUT_QUERY     = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] span;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] outcome;
    logic [3:0] slot;
  } rsp_t;

  // A request word as it travels down the chain of slot cells.
  typedef struct packed {
    logic              valid;
    logic              req_type;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] end_new;
    logic              done;
    logic              hit;
    logic [2:0]        outcome;
    logic [3:0]        slot;
  } tok_t;

endpackage

>>> src/drmt_cell.sv
module drmt_cell import drmt_pkg::*; #(
  parameter int unsigned CellIdx  = 0,
  parameter bit          LastCell = 1'b0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  tok_t tok_i,
  output tok_t tok_o,
  output logic used_o
);

  logic              used_q, used_d;
  logic              valid_q;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [ADDR_W-1:0] end_q, end_d;
  tok_t              tok_q, tok_d;

  logic in_range;
  logic overlap;
  logic claim_merge;
  logic claim_place;

  // Ends are stored already saturated, so the hull of a merge is just min/max.
  assign in_range = used_q && (tok_i.addr >= start_q) && (tok_i.addr < end_q);
  assign overlap  = used_q && (tok_i.addr <= end_q) && (tok_i.end_new >= start_q);

  assign claim_merge = tok_i.valid && !tok_i.done && overlap;
  // Used cells are contiguous from slot zero, so the first free cell a word
  // reaches is the append point; the last cell takes the word when full.
  assign claim_place = tok_i.valid && !tok_i.done && !overlap && (!used_q || LastCell);

  always_comb begin
    tok_d   = tok_i;
    used_d  = used_q;
    start_d = start_q;
    end_d   = end_q;
    if (tok_i.valid && (tok_i.req_type == REQ_QUERY) && in_range) begin
      tok_d.hit = 1'b1;
    end
    if (claim_merge) begin
      tok_d.done    = 1'b1;
      tok_d.outcome = OUT_MERGED;
      tok_d.slot    = 4'(CellIdx);
      start_d       = (tok_i.addr < start_q) ? tok_i.addr : start_q;
      end_d         = (tok_i.end_new > end_q) ? tok_i.end_new : end_q;
    end else if (claim_place) begin
      tok_d.done    = 1'b1;
      tok_d.outcome = used_q ? OUT_OVERWROTE : OUT_APPENDED;
      tok_d.slot    = 4'(CellIdx);
      used_d        = 1'b1;
      start_d       = tok_i.addr;
      end_d         = tok_i.end_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      used_q  <= used_d;
      valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      start_q <= start_d;
      end_q   <= end_d;
      tok_q   <= tok_d;
    end
  end

  // The valid bit comes from the reset flop; the rest of the word needs no reset.
  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

  assign used_o = used_q;

endmodule

>>> src/dirty_range_merge_table.sv
// Table of written address ranges built as a chain of RANGE_SLOTS cells, one
// per table entry. Each request word walks the chain one cell per cycle while
// the chain advances, and its result is offered from the last cell's register;
// a new word may enter every cycle, and words behind each other see the table
// exactly as the earlier words left it. The whole chain stalls while a finished
// result waits on out_ready_i, and in_ready_o drops for that time. Reset only
// clears the per-entry used flags and word valid bits; there is no clearing pass.
module dirty_range_merge_table import drmt_pkg::*; #(
  parameter int unsigned RANGE_SLOTS = RANGE_SLOTS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  tok_t                   chain [RANGE_SLOTS+1];
  tok_t                   head_tok;
  logic [RANGE_SLOTS-1:0] used;
  logic                   advance;
  logic [ADDR_W:0]        end_sum;

  assign advance    = !chain[RANGE_SLOTS].valid || out_ready_i;
  assign in_ready_o = advance;

  assign end_sum = {1'b0, in_data_i.addr} + {1'b0, in_data_i.span};

  // Queries and zero-length marks enter already finished; only a mark with a
  // real length is left open for some cell to claim.
  always_comb begin
    head_tok.valid    = in_valid_i;
    head_tok.req_type = in_data_i.req_type;
    head_tok.addr     = in_data_i.addr;
    head_tok.end_new  = end_sum[ADDR_W] ? END_LIMIT : end_sum[ADDR_W-1:0];
    head_tok.done     = (in_data_i.req_type == REQ_QUERY) || (in_data_i.span == '0);
    head_tok.hit      = 1'b0;
    head_tok.outcome  = (in_data_i.req_type == REQ_QUERY) ? OUT_QUERY : OUT_IGNORED;
    head_tok.slot     = '0;
  end

  assign chain[0] = head_tok;

  for (genvar g = 0; g < RANGE_SLOTS; g++) begin : g_cell
    drmt_cell #(
      .CellIdx (g),
      .LastCell(g == RANGE_SLOTS - 1)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (advance),
      .tok_i (chain[g]),
      .tok_o (chain[g+1]),
      .used_o(used[g])
    );
  end

  assign out_valid_o        = chain[RANGE_SLOTS].valid;
  assign out_data_o.hit     = chain[RANGE_SLOTS].hit;
  assign out_data_o.outcome = chain[RANGE_SLOTS].outcome;
  assign out_data_o.slot    = chain[RANGE_SLOTS].slot;

  a_used_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((used >> 1) & ~used) == '0)
    else $error("used entries are not contiguous from slot zero");

  a_hit_only_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.outcome != OUT_QUERY) |-> !out_data_o.hit)
    else $error("hit set on a mark result");

  a_slot_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.outcome == OUT_QUERY || out_data_o.outcome == OUT_IGNORED)
    |-> out_data_o.slot == '0)
    else $error("nonzero slot on a query or ignored mark");

  a_word_finished : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chain[RANGE_SLOTS].done)
    else $error("mark word left the chain unclaimed");

endmodule

>>> tb/drmt_checker.sv
`timescale 1ns / 100ps

module drmt_checker import drmt_pkg::*; #(
  parameter int unsigned RANGE_SLOTS = RANGE_SLOTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  req_t        in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rsp_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [ADDR_W-1:0] span_start [RANGE_SLOTS];
  logic [ADDR_W-1:0] span_len [RANGE_SLOTS];
  int unsigned       entries_used;
  rsp_t              expected_rsp_q [$];
  int unsigned       mismatch_n;

  // The end of a range is exclusive and clips at the top of the address space.
  function automatic logic [ADDR_W-1:0] capped_end(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] len);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, len};
    return sum[ADDR_W] ? END_LIMIT : sum[ADDR_W-1:0];
  endfunction

  // Applies one request word to the shadow table and returns its answer.
  function automatic rsp_t track_request(input req_t r);
    rsp_t              rsp;
    int                i;
    logic [ADDR_W-1:0] e;
    logic [ADDR_W-1:0] new_end;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    rsp = '0;
    if (r.req_type == REQ_QUERY) begin
      rsp.outcome = OUT_QUERY;
      for (i = 0; i < entries_used; i++) begin
        e = capped_end(span_start[i], span_len[i]);
        if (r.addr >= span_start[i] && r.addr < e) begin
          rsp.hit = 1'b1;
        end
      end
      return rsp;
    end
    if (r.span == '0) begin
      rsp.outcome = OUT_IGNORED;
      return rsp;
    end
    new_end = capped_end(r.addr, r.span);
    // Only the lowest entry that overlaps or touches absorbs the new range.
    for (i = 0; i < entries_used; i++) begin
      e = capped_end(span_start[i], span_len[i]);
      if (r.addr <= e && new_end >= span_start[i]) begin
        lo = (r.addr < span_start[i]) ? r.addr : span_start[i];
        hi = (new_end > e) ? new_end : e;
        span_start[i] = lo;
        span_len[i] = hi - lo;
        rsp.outcome = OUT_MERGED;
        rsp.slot = i[3:0];
        return rsp;
      end
    end
    if (entries_used < RANGE_SLOTS) begin
      i = entries_used;
      entries_used++;
      rsp.outcome = OUT_APPENDED;
    end else begin
      i = RANGE_SLOTS - 1;
      rsp.outcome = OUT_OVERWROTE;
    end
    span_start[i] = r.addr;
    span_len[i] = r.span;
    rsp.slot = i[3:0];
    return rsp;
  endfunction

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      entries_used = 0;
      mismatch_n = 0;
      expected_rsp_q.delete();
    end else begin
      // A result word can never belong to a request word taken at the same edge,
      // so the output side is checked before the new prediction is queued.
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          if (mismatch_n < 10) begin
            $display("range table: unexpected result word hit=%0d outcome=%0d slot=%0d",
                     out_data_i.hit, out_data_i.outcome, out_data_i.slot);
          end
          mismatch_n++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (out_data_i.hit !== exp_rsp.hit || out_data_i.outcome !== exp_rsp.outcome ||
              out_data_i.slot !== exp_rsp.slot) begin
            if (mismatch_n < 10) begin
              $display("range table mismatch: expected hit=%0d outcome=%0d slot=%0d, %s",
                       exp_rsp.hit, exp_rsp.outcome, exp_rsp.slot,
                       $sformatf("got hit=%0d outcome=%0d slot=%0d",
                                 out_data_i.hit, out_data_i.outcome, out_data_i.slot));
            end
            mismatch_n++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_rsp_q.push_back(track_request(in_data_i));
      end
    end
    fail_count_o <= mismatch_n;
    pending_o <= expected_rsp_q.size();
  end

endmodule

>>> tb/dirty_range_merge_table_tb.sv
`timescale 1ns / 100ps

module dirty_range_merge_table_tb;
  import drmt_pkg::*;

  localparam int unsigned SLOTS = RANGE_SLOTS_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned LONG_HOLD_AT = 600;
  localparam int unsigned LONG_HOLD_CYCLES = 400;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  int unsigned fail_count;
  int unsigned pending;
  bit          tx_steady = 1'b0;

  dirty_range_merge_table #(
    .RANGE_SLOTS(SLOTS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  drmt_checker #(
    .RANGE_SLOTS(SLOTS)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("dirty_range_merge_table regression: fail");
    $finish;
  end

  // Offers one request word after a random gap (none in steady stretches) and waits until it is taken.
  task automatic send_req(input logic kind, input logic [ADDR_W-1:0] a,
                          input logic [ADDR_W-1:0] n);
    int unsigned gap;
    req_t        w;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    w.req_type = kind;
    w.addr = a;
    w.span = n;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // The pending count is registered behind the accepting edge, so wait for the next edge first.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly eight small windows so that ranges collide, plus the very top of memory and any address.
  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return END_LIMIT - $urandom_range(0, 255);
      default: return ($urandom_range(0, 7) << 20) | $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_span();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom();
      2: return END_LIMIT;
      default: return $urandom_range(1, 256);
    endcase
  endfunction

  // Result side: random stalls, bursts without stalls, and one long hold-off
  // that lets the chain fill and push back on the request side.
  initial begin : result_side
    int unsigned stall;
    int unsigned taken;
    bit          rx_steady;
    taken = 0;
    rx_steady = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      stall = rx_steady ? 0 : $urandom_range(0, 17);
      if (taken == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] last_start;
    logic [ADDR_W-1:0] last_end;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] n;
    logic [ADDR_W:0]   sum;
    int unsigned       pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, ignored mark, touching merges on both sides,
    // a saturated range at the top of memory, then filling past the last slot.
    send_req(REQ_QUERY, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_MARK, 32'h0000_1000, 32'h0000_0000);
    send_req(REQ_MARK, 32'h0000_1000, 32'h0000_0100);
    send_req(REQ_QUERY, 32'h0000_1000, 32'hFFFF_FFFF);
    send_req(REQ_QUERY, 32'h0000_10FF, 32'h0000_0000);
    send_req(REQ_QUERY, 32'h0000_1100, 32'h0000_0000);
    send_req(REQ_MARK, 32'h0000_1100, 32'h0000_0010);
    send_req(REQ_MARK, 32'h0000_0F00, 32'h0000_0100);
    send_req(REQ_MARK, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_req(REQ_QUERY, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(REQ_QUERY, 32'hFFFF_FFFE, 32'h0000_0000);
    for (int k = 1; k <= 15; k++) begin
      send_req(REQ_MARK, 32'h4000_0000 + (k << 20), 32'h0000_0010);
    end
    hold_until_drained();

    last_start = 32'h0000_1000;
    last_end = 32'h0000_1100;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) hold_until_drained();
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        n = pick_span();
        if (pick == 4) begin
          a = last_end;
        end else if (pick == 5) begin
          a = last_start - n;
        end else begin
          a = pick_addr();
        end
        if (n != '0) begin
          sum = {1'b0, a} + {1'b0, n};
          last_start = a;
          last_end = sum[ADDR_W] ? END_LIMIT : sum[ADDR_W-1:0];
        end
        send_req(REQ_MARK, a, n);
      end else begin
        case (pick)
          6: a = last_start;
          7: a = last_end - 1;
          8: a = last_end;
          default: a = pick_addr();
        endcase
        send_req(REQ_QUERY, a, $urandom());
      end
    end

    hold_until_drained();
    repeat (4 * SLOTS) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("dirty_range_merge_table regression: pass");
    end else begin
      $display("dirty_range_merge_table regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
src/drmt_pkg.sv
src/drmt_cell.sv
src/dirty_range_merge_table.sv
tb/drmt_checker.sv
tb/dirty_range_merge_table_tb.sv
